// File: hw/rtl/cartridge_bank_mapper_irq_core_defines.svh
// Assertion shorthands used by the RTL of the mapper core.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_CORE_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cbm_pkg.sv
package cbm_pkg;

    localparam int RAM_DEPTH      = 1024;
    localparam int RAM_ADDR_W     = $clog2(RAM_DEPTH);
    localparam int PRG_BANK_COUNT = 64;
    localparam int CHR_BANK_COUNT = 256;

    // Both bank counts are powers of two, so wrapping keeps only the low bits.
    localparam logic [7:0] PRG_MASK = 8'(PRG_BANK_COUNT - 1);
    localparam logic [7:0] CHR_MASK = 8'(CHR_BANK_COUNT - 1);
    localparam logic [7:0] PRG_SECOND_LAST = 8'(PRG_BANK_COUNT - 2);
    localparam logic [7:0] PRG_LAST        = 8'(PRG_BANK_COUNT - 1);

    typedef enum logic [1:0] {
        REQ_CPU_WRITE = 2'd0,
        REQ_CPU_READ  = 2'd1,
        REQ_PPU_FETCH = 2'd2,
        REQ_SCANLINE  = 2'd3
    } req_type_t;

    // Register select: address AND E001.
    localparam logic [15:0] SEL_MASK     = 16'hE001;
    localparam logic [15:0] SEL_COMMAND  = 16'h8000;
    localparam logic [15:0] SEL_BANK     = 16'h8001;
    localparam logic [15:0] SEL_MIRROR   = 16'hA000;
    localparam logic [15:0] SEL_PROTECT  = 16'hA001;
    localparam logic [15:0] SEL_IRQ_LAT  = 16'hC000;
    localparam logic [15:0] SEL_IRQ_RLD  = 16'hC001;
    localparam logic [15:0] SEL_IRQ_OFF  = 16'hE000;
    localparam logic [15:0] SEL_IRQ_ON   = 16'hE001;

    localparam logic [3:0] RAM_WINDOW_PAGE = 4'h7;

    // Bit positions in the command byte.
    localparam int CMD_RAM_EN   = 5;
    localparam int CMD_PRG_SWAP = 6;
    localparam int CMD_CHR_SWAP = 7;

    // Bit positions in the RAM-protect byte.
    localparam int PROT_LO_WR = 4;
    localparam int PROT_LO_RD = 5;
    localparam int PROT_HI_WR = 6;
    localparam int PROT_HI_RD = 7;

    typedef logic [7:0] bank_array_t [8];

    localparam bank_array_t BANK_RESET = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};

    // Wraps an 8-bit bank number to a power-of-two bank count given as its mask.
    function automatic logic [7:0] bank_wrap(input logic [7:0] value, input logic [7:0] mask);
        return value & mask;
    endfunction

endpackage

// File: hw/rtl/cbm_ram.sv
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cartridge_bank_mapper_irq_core.sv
// Bank mapper with scanline interrupt counter and 1K internal RAM.
// Input channel s_*: one transfer per bus event. s_tuser holds the event kind
// (CPU write, CPU read, PPU pattern fetch, scanline tick); s_tdata holds the
// CPU address, the write data and the PPU address.
// Output channel m_*: exactly one transfer per input transfer, in order, with
// the RAM read data, the PRG and CHR banks, the mirroring and the IRQ level
// after the event. m_tuser is high when the block drives the read data.
// A result passes through the input register and then the result register before it is presented on m_*.
// Throughput: one event per cycle while m_tready is high. The internal RAM read is issued as the
// event is taken and returns, registered, while the event sits in the input
// register; a write of the event ahead to the same address is forwarded.
// When m_tready is low the result register holds; the input register still
// takes one more event, after which s_tready drops until the result leaves.
// Reset restores the command, bank, mirroring, protect and IRQ registers to
// their power-on values and empties both registers. RAM contents are not
// cleared and must be written before they are read.
`include "cartridge_bank_mapper_irq_core_defines.svh"

module cartridge_bank_mapper_irq_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cpu_address[15:0], write_byte[23:16], ppu_address[36:24]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_byte[7:0], prg_bank[15:8], chr_bank[23:16],
                                   // mirror_vertical[24], irq_asserted[25]
    output logic        m_tuser    // data_driven[0]
);
    import cbm_pkg::*;

    // Input register
    logic        s1_valid_reg;
    req_type_t   s1_type_reg;
    logic [15:0] s1_cpu_addr_reg;
    logic [7:0]  s1_wbyte_reg;
    logic [12:0] s1_ppu_addr_reg;

    // Mapper state
    logic [7:0]  command_byte_reg, command_byte_next;
    bank_array_t bank_regs_reg, bank_regs_next;
    logic        mirror_bit_reg, mirror_bit_next;
    logic [7:0]  ram_protect_reg, ram_protect_next;
    logic [7:0]  scan_count_reg, scan_count_next;
    logic [7:0]  scan_latch_reg, scan_latch_next;
    logic        irq_enable_reg, irq_enable_next;
    logic        reload_pending_reg, reload_pending_next;
    logic        irq_flag_reg, irq_flag_next;

    // Forwarding of a RAM write that lands in the same cycle as a read issue
    logic        byp_valid_reg;
    logic [7:0]  byp_data_reg;

    // Result register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_user_reg;

    logic        advance;
    logic        accept;
    logic [15:0] in_cpu_addr;
    logic        in_ram_window;
    logic        half_hi;
    logic        own_rd;
    logic        other_rd;
    logic        ram_we;
    logic [7:0]  ram_rdata;
    logic [7:0]  ram_data;
    logic [15:0] addr_sel;
    logic [7:0]  rd_byte;
    logic        driven;
    logic [7:0]  prg_bank;
    logic [7:0]  chr_bank;
    logic [7:0]  prg_r6;
    logic [7:0]  prg_r7;
    logic [2:0]  chr_slot;
    logic [7:0]  chr_raw;

    assign advance     = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !s1_valid_reg || advance;
    assign accept      = s_tvalid && s_tready;
    assign in_cpu_addr = s_tdata[15:0];

    assign in_ram_window = (s1_cpu_addr_reg[15:12] == RAM_WINDOW_PAGE);
    assign half_hi       = s1_cpu_addr_reg[9];
    assign own_rd   = half_hi ? ram_protect_reg[PROT_HI_RD] : ram_protect_reg[PROT_LO_RD];
    assign other_rd = half_hi ? ram_protect_reg[PROT_LO_RD] : ram_protect_reg[PROT_HI_RD];

    // A RAM write needs both the read and the write enable of its half.
    assign ram_we = advance && (s1_type_reg == REQ_CPU_WRITE) && in_ram_window
                    && command_byte_reg[CMD_RAM_EN]
                    && (half_hi ? (ram_protect_reg[PROT_HI_RD] && ram_protect_reg[PROT_HI_WR])
                                : (ram_protect_reg[PROT_LO_RD] && ram_protect_reg[PROT_LO_WR]));

    cbm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_cpu_addr_reg[RAM_ADDR_W-1:0]),
        .wdata (s1_wbyte_reg),
        .re    (accept),
        .raddr (in_cpu_addr[RAM_ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_data = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign addr_sel = s1_cpu_addr_reg & SEL_MASK;

    always_comb
    begin
        command_byte_next   = command_byte_reg;
        bank_regs_next      = bank_regs_reg;
        mirror_bit_next     = mirror_bit_reg;
        ram_protect_next    = ram_protect_reg;
        scan_count_next     = scan_count_reg;
        scan_latch_next     = scan_latch_reg;
        irq_enable_next     = irq_enable_reg;
        reload_pending_next = reload_pending_reg;
        irq_flag_next       = irq_flag_reg;

        case (s1_type_reg)
            REQ_CPU_WRITE:
            begin
                if (!in_ram_window)
                begin
                    case (addr_sel)
                        SEL_COMMAND: command_byte_next = s1_wbyte_reg;
                        SEL_BANK:    bank_regs_next[command_byte_reg[2:0]] = s1_wbyte_reg;
                        SEL_MIRROR:  mirror_bit_next = s1_wbyte_reg[0];
                        SEL_PROTECT: ram_protect_next = s1_wbyte_reg;
                        SEL_IRQ_LAT: scan_latch_next = s1_wbyte_reg;
                        SEL_IRQ_RLD: reload_pending_next = 1'b1;
                        SEL_IRQ_OFF:
                        begin
                            irq_flag_next   = 1'b0;
                            irq_enable_next = 1'b0;
                        end
                        SEL_IRQ_ON:  irq_enable_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            REQ_SCANLINE:
            begin
                if ((scan_count_reg == 8'd0) || reload_pending_reg)
                begin
                    scan_count_next     = scan_latch_reg;
                    reload_pending_next = 1'b0;
                end
                else
                begin
                    scan_count_next = scan_count_reg - 8'd1;
                end
                if ((scan_count_next == 8'd0) && irq_enable_reg)
                begin
                    irq_flag_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // PRG bank, looked up after the write of this event has taken effect.
    always_comb
    begin
        prg_r6   = bank_wrap(bank_regs_next[6], PRG_MASK);
        prg_r7   = bank_wrap(bank_regs_next[7], PRG_MASK);
        prg_bank = 8'd0;
        if (((s1_type_reg == REQ_CPU_WRITE) || (s1_type_reg == REQ_CPU_READ))
            && s1_cpu_addr_reg[15])
        begin
            case (s1_cpu_addr_reg[14:13])
                2'd0:    prg_bank = command_byte_next[CMD_PRG_SWAP] ? PRG_SECOND_LAST : prg_r6;
                2'd1:    prg_bank = prg_r7;
                2'd2:    prg_bank = command_byte_next[CMD_PRG_SWAP] ? prg_r6 : PRG_SECOND_LAST;
                default: prg_bank = PRG_LAST;
            endcase
        end
    end

    // CHR bank: the low four slots are 2K pairs of registers 0 and 1.
    always_comb
    begin
        chr_slot = s1_ppu_addr_reg[12:10] ^ {command_byte_reg[CMD_CHR_SWAP], 2'b00};
        if (!chr_slot[2])
        begin
            chr_raw = {bank_regs_reg[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};
        end
        else
        begin
            chr_raw = bank_regs_reg[chr_slot - 3'd2];
        end
        chr_bank = (s1_type_reg == REQ_PPU_FETCH) ? bank_wrap(chr_raw, CHR_MASK) : 8'd0;
    end

    // A disabled half reads as zero while the other half is readable.
    always_comb
    begin
        driven  = (s1_type_reg == REQ_CPU_READ) && in_ram_window
                  && command_byte_reg[CMD_RAM_EN] && (own_rd || other_rd);
        rd_byte = (driven && own_rd) ? ram_data : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            byp_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            command_byte_reg   <= 8'd0;
            bank_regs_reg      <= BANK_RESET;
            mirror_bit_reg     <= 1'b0;
            ram_protect_reg    <= 8'd0;
            scan_count_reg     <= 8'd0;
            scan_latch_reg     <= 8'd0;
            irq_enable_reg     <= 1'b0;
            reload_pending_reg <= 1'b0;
            irq_flag_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg  <= 1'b1;
                byp_valid_reg <= ram_we
                                 && (s1_cpu_addr_reg[RAM_ADDR_W-1:0]
                                     == in_cpu_addr[RAM_ADDR_W-1:0]);
            end
            else if (advance)
            begin
                s1_valid_reg  <= 1'b0;
                byp_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                command_byte_reg   <= command_byte_next;
                bank_regs_reg      <= bank_regs_next;
                mirror_bit_reg     <= mirror_bit_next;
                ram_protect_reg    <= ram_protect_next;
                scan_count_reg     <= scan_count_next;
                scan_latch_reg     <= scan_latch_next;
                irq_enable_reg     <= irq_enable_next;
                reload_pending_reg <= reload_pending_next;
                irq_flag_reg       <= irq_flag_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg     <= req_type_t'(s_tuser);
            s1_cpu_addr_reg <= in_cpu_addr;
            s1_wbyte_reg    <= s_tdata[23:16];
            s1_ppu_addr_reg <= s_tdata[36:24];
            byp_data_reg    <= s1_wbyte_reg;
        end
        if (advance)
        begin
            out_data_reg <= {6'd0, irq_flag_next, ~mirror_bit_next, chr_bank, prg_bank, rd_byte};
            out_user_reg <= driven;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `CBM_ASSERT_SAME(a_irq_needs_enable, $rose(irq_flag_reg), $past(irq_enable_reg),
        "IRQ flag rose while the interrupt was disabled")
    `CBM_ASSERT_NEXT(a_state_holds_on_stall, !advance,
        $stable(command_byte_reg) && $stable(ram_protect_reg) && $stable(scan_count_reg),
        "mapper state changed without an event advancing")
    `CBM_ASSERT_SAME(a_bypass_has_item, byp_valid_reg, s1_valid_reg,
        "RAM forwarding is armed with no event in the input register")
    `CBM_ASSERT_SAME(a_undriven_reads_zero, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0,
        "read data is nonzero on an undriven result")

endmodule
